@@ design/wfha_pkg.sv @@
// ----------------------------------------------------------------------------
// wfha_pkg
// Shared types and codes of the worst-fit heap allocator.
// ----------------------------------------------------------------------------
package wfha_pkg;

  localparam int MaxPartitionsDefault = 16;
  localparam int OffsetBitsDefault    = 16;

  localparam logic [16:0] HEAP_SIZE_RESET   = 17'd4096;
  localparam logic [6:0]  HEADER_SIZE_RESET = 7'd16;

  localparam logic [1:0] REG_HEAP_SIZE   = 2'd0;
  localparam logic [1:0] REG_HEADER_SIZE = 2'd1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_MOVE  = 2'd1;
  localparam logic [1:0] KIND_FREE  = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_PROC,
    S_SCAN_DONE,
    S_SHF_RD,
    S_SHF_PROC,
    S_SPL_A,
    S_SPL_B,
    S_ANS,
    S_CMP_RD,
    S_CMP_PROC,
    S_CMP_END,
    S_FREE_RD,
    S_FREE_PROC,
    S_FREE_END
  } state_t;

  typedef struct packed {
    logic        init;
    logic [16:0] heap;
    logic [6:0]  hdr;
  } cfg_t;

endpackage

@@ design/wfha_core.sv @@
// ----------------------------------------------------------------------------
// wfha_core
// Partition table memory and the sequencer that scans, splits, compacts
// and merges it, with the result word register.
// ----------------------------------------------------------------------------
module wfha_core #(
  parameter int MAX_PARTITIONS = wfha_pkg::MaxPartitionsDefault,
  parameter int OFFSET_BITS    = wfha_pkg::OffsetBitsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  wfha_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [15:0]       request_size,
  input  logic [15:0]       free_offset,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        kind,
  output logic              status,
  output logic [15:0]       data_offset,
  output logic [15:0]       move_source,
  output logic [15:0]       move_dest,
  output logic [16:0]       move_length,
  output logic              last
);

  localparam int OB   = OFFSET_BITS;
  localparam int EW   = OB + 1;
  localparam int AW   = (OB + 2 > 19) ? OB + 2 : 19;
  localparam int IW   = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CNTW = $clog2(MAX_PARTITIONS + 1);

  wfha_pkg::state_t state, state_next;

  logic [EW-1:0] mem [MAX_PARTITIONS];
  logic [EW-1:0] rdata;
  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;

  logic [CNTW-1:0] idx, idx_next, cnt, cnt_next, wr, wr_next;
  logic [AW-1:0]   cur, cur_next, dst, dst_next, freeb, freeb_next;
  logic [AW-1:0]   need, need_next, where, where_next, best_off, best_off_next;
  logic            found, found_next, retry, retry_next, hit, hit_next;
  logic            ans_fail, ans_fail_next, pend_occ, pend_occ_next;
  logic [IW-1:0]   best_idx, best_idx_next;
  logic [OB-1:0]   best_size, best_size_next, pend_size, pend_size_next;

  logic [AW-1:0] heap_e, hdr_e, heap_top, eff_heap, eff_hdr, req_e;
  logic          e_occ;
  logic [OB-1:0] e_size;
  logic [AW-1:0] span;
  logic          at_last, out_free, emit, move_due, split_ok, shift_due, match;

  logic [1:0]  emit_kind;
  logic        emit_status;
  logic [15:0] emit_data, emit_src, emit_dst;
  logic [16:0] emit_len;

  assign heap_e   = AW'(cfg.heap);
  assign hdr_e    = AW'(cfg.hdr);
  assign heap_top = AW'(1) << OB;
  assign eff_heap = (heap_e < AW'(64)) ? AW'(64) : ((heap_e > heap_top) ? heap_top : heap_e);
  assign eff_hdr  = (hdr_e < AW'(4)) ? AW'(4) : ((hdr_e > AW'(64)) ? AW'(64) : hdr_e);
  assign req_e    = AW'(request_size);

  assign e_occ     = rdata[OB];
  assign e_size    = rdata[OB-1:0];
  assign span      = eff_hdr + AW'(e_size);
  assign at_last   = (idx + CNTW'(1)) == cnt;
  assign out_free  = !out_valid || !out_stall;
  assign move_due  = e_occ && (cur != dst);
  assign split_ok  = (AW'(best_size) >= need + eff_hdr + AW'(4))
                     && (cnt < CNTW'(MAX_PARTITIONS));
  assign shift_due = cnt > (CNTW'(best_idx) + CNTW'(1));
  assign match     = e_occ && !hit && (cur + eff_hdr == where);
  assign in_stall  = (state != wfha_pkg::S_IDLE) || cfg.init;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wfha_pkg::S_INIT: state_next = wfha_pkg::S_IDLE;
      wfha_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = (mode == wfha_pkg::MODE_FREE) ? wfha_pkg::S_FREE_RD
                                                     : wfha_pkg::S_SCAN_RD;
        end
      end
      wfha_pkg::S_SCAN_RD:   state_next = wfha_pkg::S_SCAN_PROC;
      wfha_pkg::S_SCAN_PROC: state_next = at_last ? wfha_pkg::S_SCAN_DONE
                                                  : wfha_pkg::S_SCAN_RD;
      wfha_pkg::S_SCAN_DONE: begin
        if (found) begin
          if (split_ok) begin
            state_next = shift_due ? wfha_pkg::S_SHF_RD : wfha_pkg::S_SPL_A;
          end else begin
            state_next = wfha_pkg::S_ANS;
          end
        end else begin
          state_next = retry ? wfha_pkg::S_ANS : wfha_pkg::S_CMP_RD;
        end
      end
      wfha_pkg::S_SHF_RD:   state_next = wfha_pkg::S_SHF_PROC;
      wfha_pkg::S_SHF_PROC: begin
        state_next = (idx[IW-1:0] == best_idx + IW'(1)) ? wfha_pkg::S_SPL_A
                                                        : wfha_pkg::S_SHF_RD;
      end
      wfha_pkg::S_SPL_A: state_next = wfha_pkg::S_SPL_B;
      wfha_pkg::S_SPL_B: state_next = wfha_pkg::S_ANS;
      wfha_pkg::S_ANS: begin
        if (out_free) begin
          state_next = wfha_pkg::S_IDLE;
        end
      end
      wfha_pkg::S_CMP_RD:   state_next = wfha_pkg::S_CMP_PROC;
      wfha_pkg::S_CMP_PROC: begin
        if (!move_due || out_free) begin
          state_next = at_last ? wfha_pkg::S_CMP_END : wfha_pkg::S_CMP_RD;
        end
      end
      wfha_pkg::S_CMP_END:   state_next = wfha_pkg::S_SCAN_RD;
      wfha_pkg::S_FREE_RD:   state_next = wfha_pkg::S_FREE_PROC;
      wfha_pkg::S_FREE_PROC: state_next = at_last ? wfha_pkg::S_FREE_END
                                                  : wfha_pkg::S_FREE_RD;
      wfha_pkg::S_FREE_END: begin
        if (out_free) begin
          state_next = wfha_pkg::S_IDLE;
        end
      end
      default: state_next = wfha_pkg::S_INIT;
    endcase
    if (cfg.init) begin
      state_next = wfha_pkg::S_INIT;
    end
  end

  always_comb begin
    idx_next       = idx;
    cnt_next       = cnt;
    wr_next        = wr;
    cur_next       = cur;
    dst_next       = dst;
    freeb_next     = freeb;
    need_next      = need;
    where_next     = where;
    best_off_next  = best_off;
    best_idx_next  = best_idx;
    best_size_next = best_size;
    found_next     = found;
    retry_next     = retry;
    hit_next       = hit;
    ans_fail_next  = ans_fail;
    pend_occ_next  = pend_occ;
    pend_size_next = pend_size;
    we             = 1'b0;
    re             = 1'b0;
    waddr          = '0;
    raddr          = idx[IW-1:0];
    wdata          = '0;
    emit           = 1'b0;
    emit_kind      = wfha_pkg::KIND_ALLOC;
    emit_status    = wfha_pkg::STATUS_OK;
    emit_data      = '0;
    emit_src       = '0;
    emit_dst       = '0;
    emit_len       = '0;
    case (state)
      wfha_pkg::S_INIT: begin
        we       = 1'b1;
        wdata    = {1'b0, OB'(eff_heap - eff_hdr)};
        cnt_next = CNTW'(1);
      end
      wfha_pkg::S_IDLE: begin
        idx_next   = '0;
        cur_next   = '0;
        found_next = 1'b0;
        retry_next = 1'b0;
        hit_next   = 1'b0;
        wr_next    = '0;
        where_next = AW'(free_offset);
        need_next  = (req_e == '0) ? AW'(4) : (((req_e + AW'(3)) >> 2) << 2);
      end
      wfha_pkg::S_SCAN_RD, wfha_pkg::S_CMP_RD, wfha_pkg::S_FREE_RD,
      wfha_pkg::S_SHF_RD: begin
        re = 1'b1;
      end
      wfha_pkg::S_SCAN_PROC: begin
        if (!e_occ && AW'(e_size) >= need
            && (!found || e_size > best_size)) begin
          found_next     = 1'b1;
          best_idx_next  = idx[IW-1:0];
          best_size_next = e_size;
          best_off_next  = cur;
        end
        cur_next = cur + span;
        idx_next = idx + CNTW'(1);
      end
      wfha_pkg::S_SCAN_DONE: begin
        ans_fail_next = !found;
        if (found && !split_ok) begin
          we    = 1'b1;
          waddr = best_idx;
          wdata = {1'b1, best_size};
        end
        idx_next   = cnt - CNTW'(1);
        cur_next   = '0;
        dst_next   = '0;
        freeb_next = '0;
        wr_next    = '0;
        if (!found) begin
          idx_next = '0;
        end
      end
      wfha_pkg::S_SHF_PROC: begin
        we       = 1'b1;
        waddr    = idx[IW-1:0] + IW'(1);
        wdata    = rdata;
        idx_next = idx - CNTW'(1);
      end
      wfha_pkg::S_SPL_A: begin
        we       = 1'b1;
        waddr    = best_idx + IW'(1);
        wdata    = {1'b0, OB'(AW'(best_size) - eff_hdr - need)};
        cnt_next = cnt + CNTW'(1);
      end
      wfha_pkg::S_SPL_B: begin
        we    = 1'b1;
        waddr = best_idx;
        wdata = {1'b1, OB'(need)};
      end
      wfha_pkg::S_ANS: begin
        emit        = out_free;
        emit_kind   = wfha_pkg::KIND_ALLOC;
        emit_status = ans_fail ? wfha_pkg::STATUS_FAIL : wfha_pkg::STATUS_OK;
        emit_data   = ans_fail ? 16'd0 : 16'(best_off + eff_hdr);
      end
      wfha_pkg::S_CMP_PROC: begin
        if (!move_due || out_free) begin
          if (e_occ) begin
            emit      = move_due;
            emit_kind = wfha_pkg::KIND_MOVE;
            emit_src  = 16'(cur);
            emit_dst  = 16'(dst);
            emit_len  = 17'(span);
            we        = 1'b1;
            waddr     = wr[IW-1:0];
            wdata     = rdata;
            wr_next   = wr + CNTW'(1);
            dst_next  = dst + span;
          end else begin
            freeb_next = freeb + span;
          end
          cur_next = cur + span;
          idx_next = idx + CNTW'(1);
        end
      end
      wfha_pkg::S_CMP_END: begin
        cnt_next = wr;
        if (freeb != '0 && wr < CNTW'(MAX_PARTITIONS)) begin
          we       = 1'b1;
          waddr    = wr[IW-1:0];
          wdata    = {1'b0, OB'(freeb - eff_hdr)};
          cnt_next = wr + CNTW'(1);
        end
        retry_next = 1'b1;
        idx_next   = '0;
        cur_next   = '0;
        found_next = 1'b0;
      end
      wfha_pkg::S_FREE_PROC: begin
        if (match) begin
          hit_next = 1'b1;
        end
        if (idx == '0) begin
          pend_occ_next  = e_occ && !match;
          pend_size_next = e_size;
        end else if (!pend_occ && !(e_occ && !match)) begin
          pend_size_next = OB'(AW'(pend_size) + span);
        end else begin
          we             = 1'b1;
          waddr          = wr[IW-1:0];
          wdata          = {pend_occ, pend_size};
          wr_next        = wr + CNTW'(1);
          pend_occ_next  = e_occ && !match;
          pend_size_next = e_size;
        end
        cur_next = cur + span;
        idx_next = idx + CNTW'(1);
      end
      wfha_pkg::S_FREE_END: begin
        if (out_free) begin
          we          = 1'b1;
          waddr       = wr[IW-1:0];
          wdata       = {pend_occ, pend_size};
          cnt_next    = wr + CNTW'(1);
          emit        = 1'b1;
          emit_kind   = wfha_pkg::KIND_FREE;
          emit_status = hit ? wfha_pkg::STATUS_OK : wfha_pkg::STATUS_FAIL;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wfha_pkg::S_INIT;
      out_valid <= 1'b0;
      cnt       <= CNTW'(1);
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    wr        <= wr_next;
    cur       <= cur_next;
    dst       <= dst_next;
    freeb     <= freeb_next;
    need      <= need_next;
    where     <= where_next;
    best_off  <= best_off_next;
    best_idx  <= best_idx_next;
    best_size <= best_size_next;
    found     <= found_next;
    retry     <= retry_next;
    hit       <= hit_next;
    ans_fail  <= ans_fail_next;
    pend_occ  <= pend_occ_next;
    pend_size <= pend_size_next;
    if (emit) begin
      kind        <= emit_kind;
      status      <= emit_status;
      data_offset <= emit_data;
      move_source <= emit_src;
      move_dest   <= emit_dst;
      move_length <= emit_len;
      last        <= (emit_kind != wfha_pkg::KIND_MOVE);
    end
  end

endmodule

@@ design/worst_fit_heap_allocator_top.sv @@
// ----------------------------------------------------------------------------
// worst_fit_heap_allocator_top
// Worst-fit heap allocator with compaction over a partition table memory.
// Allocate: a scan over the table, and on a split a shift of the partitions
// above the chosen one before the split is written; no fit compacts the
// table, closes it and runs a second scan.
// Free: one pass over the table that merges free neighbours. Output stalls can hold any word.
// One request is in work at a time; the table memory port sets the rate.
// Reset rebuilds the table through the init state; a register write is
// registered first and holds the input stalled until the rebuild is done.
// ----------------------------------------------------------------------------
module worst_fit_heap_allocator_top #(
  parameter int MAX_PARTITIONS = wfha_pkg::MaxPartitionsDefault,
  parameter int OFFSET_BITS    = wfha_pkg::OffsetBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [15:0] request_size,
  input  logic [15:0] free_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic        status,
  output logic [15:0] data_offset,
  output logic [15:0] move_source,
  output logic [15:0] move_dest,
  output logic [16:0] move_length,
  output logic        last
);

  wfha_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heap <= wfha_pkg::HEAP_SIZE_RESET;
      cfg.hdr  <= wfha_pkg::HEADER_SIZE_RESET;
      cfg.init <= 1'b0;
    end else begin
      cfg.init <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          wfha_pkg::REG_HEAP_SIZE: begin
            cfg.heap <= cfg_data;
            cfg.init <= 1'b1;
          end
          wfha_pkg::REG_HEADER_SIZE: begin
            cfg.hdr  <= cfg_data[6:0];
            cfg.init <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  wfha_core #(
    .MAX_PARTITIONS(MAX_PARTITIONS),
    .OFFSET_BITS   (OFFSET_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .request_size(request_size),
    .free_offset (free_offset),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .status      (status),
    .data_offset (data_offset),
    .move_source (move_source),
    .move_dest   (move_dest),
    .move_length (move_length),
    .last        (last)
  );

endmodule
